/* rtl/spi_nor_flash_command_sequencer_unit_macros.svh */
// Assertion macros shared by the SPI NOR flash command sequencer.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SNF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SNF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/snf_pkg.sv */
// Types and constants shared by the SPI NOR flash command sequencer.
`default_nettype none
package snf_pkg;

   localparam int POS_W   = 24;
   localparam int LEN_W   = 11;
   localparam int CNT_W   = 10;
   localparam int CHUNK_W = 13;
   localparam int ROOM_W  = 10;

   localparam int RESULT_LIMIT = 64;
   localparam int MIN_CHUNK    = 16;

   localparam logic [2:0] FUNC_SEEK  = 3'd0;
   localparam logic [2:0] FUNC_READ  = 3'd1;
   localparam logic [2:0] FUNC_WRITE = 3'd2;
   localparam logic [2:0] FUNC_ERASE = 3'd3;
   localparam logic [2:0] FUNC_ID    = 3'd4;

   localparam logic [7:0] OP_WREN    = 8'h06;
   localparam logic [7:0] OP_PROGRAM = 8'h02;
   localparam logic [7:0] OP_READ    = 8'h03;
   localparam logic [7:0] OP_ERASE   = 8'h20;
   localparam logic [7:0] OP_ID      = 8'h9F;

   localparam logic [CNT_W-1:0] ID_BYTES = 10'd3;

   typedef enum logic [2:0] {
      CMD_STATUS = 3'd0,
      CMD_ERASE  = 3'd1,
      CMD_ID     = 3'd2,
      CMD_READ   = 3'd3,
      CMD_WRITE  = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic               status;
      logic [POS_W-1:0]   position;
      logic [POS_W-1:0]   addr;
      logic [LEN_W-1:0]   len;
      logic [CHUNK_W-1:0] chunk;
      logic [ROOM_W-1:0]  room;
   } cmd_type;

   typedef struct packed {
      logic             is_transaction;
      logic [7:0]       spi_opcode;
      logic             has_address;
      logic [POS_W-1:0] spi_address;
      logic [CNT_W-1:0] data_count;
      logic             poll_after;
      logic             status;
      logic [POS_W-1:0] position;
      logic             last;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/snf_fifo.sv */
// Small register-based first-in first-out queue.
`default_nettype none
module snf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      rdata
);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NUM_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NUM_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == NUM_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

/* rtl/snf_front.sv */
// Request front end: range checks, position tracking and command classification.
`default_nettype none
module snf_front #(
   parameter int FLASH_BYTES  = 8388608,
   parameter int PAGE_BYTES   = 256,
   parameter int SECTOR_BYTES = 4096,
   parameter int BUFFER_BYTES = 512,
   parameter int MAX_REQUEST  = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   output logic                            full,
   input  wire logic [2:0]                 func,
   input  wire logic [snf_pkg::POS_W-1:0]  target_addr,
   input  wire logic [snf_pkg::LEN_W-1:0]  byte_count,
   input  wire logic [snf_pkg::CNT_W-1:0]  max_chunk,
   output logic                            cmd_push,
   input  wire logic                       cmd_full,
   output snf_pkg::cmd_type                cmd
);
   localparam int DIVISOR_MAX = (PAGE_BYTES > SECTOR_BYTES) ? PAGE_BYTES : SECTOR_BYTES;
   localparam int DIV_W       = $clog2(DIVISOR_MAX + 1);
   localparam int WIDE_W      = snf_pkg::POS_W + 1;
   localparam int CW          = snf_pkg::CHUNK_W;
   localparam int PROD_W      = 2 * snf_pkg::POS_W + 1;
   localparam int PAGE_SH     = snf_pkg::POS_W + $clog2(PAGE_BYTES);
   localparam int SECT_SH     = snf_pkg::POS_W + $clog2(SECTOR_BYTES);
   localparam longint unsigned PAGE_RECIP =
      ((64'd1 << PAGE_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
   localparam longint unsigned SECT_RECIP =
      ((64'd1 << SECT_SH) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES);

   typedef enum logic [2:0] {
      F_IDLE  = 3'b001,
      F_DIV   = 3'b010,
      F_ISSUE = 3'b100
   } front_state_type;

   front_state_type                state_ff, state_in;
   logic [2:0]                     func_ff, func_in;
   logic [snf_pkg::POS_W-1:0]      target_ff, target_in;
   logic [snf_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [CW-1:0]                  chunk_ff, chunk_in;
   logic [snf_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [snf_pkg::POS_W-1:0]      dvd_ff, dvd_in;
   logic                           sel_sector_ff, sel_sector_in;
   logic [snf_pkg::POS_W-1:0]      quot_ff, quot_in;
   logic [DIV_W-1:0]               rem_ff, rem_in;
   logic                           step_ff, step_in;
   logic                           accept;
   logic [PROD_W-1:0]              prod_page, prod_sect;
   logic [snf_pkg::POS_W-1:0]      quot_calc;
   logic [snf_pkg::POS_W-1:0]      back_mul;
   logic [CW-1:0]                  mc_ext;
   logic [CW-1:0]                  chunk_eff;
   logic [WIDE_W-1:0]              pos_len;
   logic [WIDE_W-1:0]              len_wide;
   logic                           target_out;
   logic [snf_pkg::POS_W-1:0]      new_pos;

   assign full   = (state_ff != F_IDLE);
   assign accept = push && !full;
   assign mc_ext = CW'(max_chunk);

   always_comb begin
      if (max_chunk == '0 || mc_ext > CW'(BUFFER_BYTES)) begin
         chunk_eff = CW'(BUFFER_BYTES);
      end else if (mc_ext < CW'(snf_pkg::MIN_CHUNK)) begin
         chunk_eff = CW'(snf_pkg::MIN_CHUNK);
      end else begin
         chunk_eff = mc_ext;
      end
   end

   // The remainder comes from a reciprocal multiplication that is exact for 24-bit values.
   assign prod_page  = PROD_W'(dvd_ff) * PROD_W'(PAGE_RECIP);
   assign prod_sect  = PROD_W'(dvd_ff) * PROD_W'(SECT_RECIP);
   assign quot_calc  = sel_sector_ff ? snf_pkg::POS_W'(prod_sect >> SECT_SH)
                                     : snf_pkg::POS_W'(prod_page >> PAGE_SH);
   assign back_mul   = sel_sector_ff ? quot_ff * snf_pkg::POS_W'(SECTOR_BYTES)
                                     : quot_ff * snf_pkg::POS_W'(PAGE_BYTES);

   assign len_wide   = WIDE_W'(len_ff);
   assign pos_len    = WIDE_W'(pos_ff) + len_wide;
   assign new_pos    = pos_len[snf_pkg::POS_W-1:0];
   assign target_out = WIDE_W'(target_ff) >= WIDE_W'(FLASH_BYTES);

   always_comb begin
      cmd          = '0;
      cmd.kind     = snf_pkg::CMD_STATUS;
      cmd.status   = 1'b0;
      cmd.position = pos_ff;
      cmd.addr     = pos_ff;
      cmd.len      = len_ff;
      cmd.chunk    = chunk_ff;
      cmd.room     = snf_pkg::ROOM_W'(PAGE_BYTES) - snf_pkg::ROOM_W'(rem_ff);
      unique case (func_ff)
         snf_pkg::FUNC_SEEK: begin
            if (target_out) begin
               cmd.status = 1'b1;
            end else begin
               cmd.position = target_ff;
            end
         end
         snf_pkg::FUNC_ERASE: begin
            if (rem_ff != '0 || target_out) begin
               cmd.status = 1'b1;
            end else begin
               cmd.kind = snf_pkg::CMD_ERASE;
               cmd.addr = target_ff;
            end
         end
         snf_pkg::FUNC_ID: begin
            cmd.kind = snf_pkg::CMD_ID;
         end
         snf_pkg::FUNC_READ, snf_pkg::FUNC_WRITE: begin
            priority if (len_ff == '0) begin
               cmd.status = 1'b0;
            end else if (len_wide > WIDE_W'(MAX_REQUEST) ||
                         pos_len > WIDE_W'(FLASH_BYTES)) begin
               cmd.status = 1'b1;
            end else if (func_ff == snf_pkg::FUNC_READ) begin
               if (len_wide > WIDE_W'(chunk_ff) * WIDE_W'(snf_pkg::RESULT_LIMIT)) begin
                  cmd.status = 1'b1;
               end else begin
                  cmd.kind     = snf_pkg::CMD_READ;
                  cmd.position = new_pos;
               end
            end else begin
               if (WIDE_W'(rem_ff) + len_wide >
                   WIDE_W'((snf_pkg::RESULT_LIMIT / 2) * PAGE_BYTES)) begin
                  cmd.status = 1'b1;
               end else begin
                  cmd.kind     = snf_pkg::CMD_WRITE;
                  cmd.position = new_pos;
               end
            end
         end
         default: begin
            cmd.status = 1'b1;
         end
      endcase
   end

   assign cmd_push = (state_ff == F_ISSUE) && !cmd_full;

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      target_in     = target_ff;
      len_in        = len_ff;
      chunk_in      = chunk_ff;
      pos_in        = pos_ff;
      dvd_in        = dvd_ff;
      sel_sector_in = sel_sector_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               func_in   = func;
               target_in = target_addr;
               len_in    = byte_count;
               chunk_in  = chunk_eff;
               rem_in    = '0;
               step_in   = 1'b0;
               if (func == snf_pkg::FUNC_WRITE) begin
                  dvd_in        = pos_ff;
                  sel_sector_in = 1'b0;
                  state_in      = F_DIV;
               end else if (func == snf_pkg::FUNC_ERASE) begin
                  dvd_in        = target_addr;
                  sel_sector_in = 1'b1;
                  state_in      = F_DIV;
               end else begin
                  state_in = F_ISSUE;
               end
            end
         end
         F_DIV: begin
            step_in = 1'b1;
            if (!step_ff) begin
               quot_in = quot_calc;
            end else begin
               rem_in   = DIV_W'(dvd_ff - back_mul);
               state_in = F_ISSUE;
            end
         end
         F_ISSUE: begin
            if (!cmd_full) begin
               pos_in   = cmd.position;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      target_ff     <= target_in;
      len_ff        <= len_in;
      chunk_ff      <= chunk_in;
      dvd_ff        <= dvd_in;
      sel_sector_ff <= sel_sector_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
   end

endmodule
`default_nettype wire

/* rtl/snf_back.sv */
// Command back end: expands one classified command into SPI transaction descriptors.
`default_nettype none
module snf_back #(
   parameter int PAGE_BYTES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_empty,
   output logic                   cmd_pop,
   input  wire snf_pkg::cmd_type  cmd,
   output logic                   rsp_push,
   input  wire logic              rsp_full,
   output snf_pkg::rsp_type       rsp
);
   localparam int CW = snf_pkg::CHUNK_W;
   localparam int RW = snf_pkg::ROOM_W;
   localparam int LW = snf_pkg::LEN_W;

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_RUN  = 2'b10
   } back_state_type;

   back_state_type            state_ff, state_in;
   snf_pkg::cmd_type          cmd_ff, cmd_in;
   logic                      phase_ff, phase_in;
   logic [snf_pkg::POS_W-1:0] addr_ff, addr_in;
   logic [LW-1:0]             rem_ff, rem_in;
   logic [RW-1:0]             room_ff, room_in;
   logic                      fits_chunk, fits_room;
   logic [LW-1:0]             read_n, write_n;

   assign fits_chunk = CW'(rem_ff) <= cmd_ff.chunk;
   assign fits_room  = LW'(room_ff) >= rem_ff;
   assign read_n     = fits_chunk ? rem_ff : LW'(cmd_ff.chunk);
   assign write_n    = fits_room ? rem_ff : LW'(room_ff);

   assign cmd_pop  = (state_ff == B_IDLE) && !cmd_empty;
   assign rsp_push = (state_ff == B_RUN) && !rsp_full;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      addr_in  = addr_ff;
      rem_in   = rem_ff;
      room_in  = room_ff;

      rsp                = '0;
      rsp.is_transaction = 1'b1;
      rsp.position       = cmd_ff.position;

      unique case (cmd_ff.kind)
         snf_pkg::CMD_ID: begin
            rsp.spi_opcode = snf_pkg::OP_ID;
            rsp.data_count = snf_pkg::ID_BYTES;
            rsp.last       = 1'b1;
         end
         snf_pkg::CMD_ERASE: begin
            if (!phase_ff) begin
               rsp.spi_opcode = snf_pkg::OP_WREN;
            end else begin
               rsp.spi_opcode  = snf_pkg::OP_ERASE;
               rsp.has_address = 1'b1;
               rsp.spi_address = addr_ff;
               rsp.poll_after  = 1'b1;
               rsp.last        = 1'b1;
            end
         end
         snf_pkg::CMD_READ: begin
            rsp.spi_opcode  = snf_pkg::OP_READ;
            rsp.has_address = 1'b1;
            rsp.spi_address = addr_ff;
            rsp.data_count  = snf_pkg::CNT_W'(read_n);
            rsp.last        = fits_chunk;
         end
         snf_pkg::CMD_WRITE: begin
            if (!phase_ff) begin
               rsp.spi_opcode = snf_pkg::OP_WREN;
            end else begin
               rsp.spi_opcode  = snf_pkg::OP_PROGRAM;
               rsp.has_address = 1'b1;
               rsp.spi_address = addr_ff;
               rsp.data_count  = snf_pkg::CNT_W'(write_n);
               rsp.poll_after  = 1'b1;
               rsp.last        = fits_room;
            end
         end
         default: begin
            rsp.is_transaction = 1'b0;
            rsp.status         = cmd_ff.status;
            rsp.last           = 1'b1;
         end
      endcase

      unique case (state_ff)
         B_IDLE: begin
            if (cmd_pop) begin
               cmd_in   = cmd;
               addr_in  = cmd.addr;
               rem_in   = cmd.len;
               room_in  = cmd.room;
               phase_in = 1'b0;
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            if (rsp_push) begin
               phase_in = !phase_ff;
               if (cmd_ff.kind == snf_pkg::CMD_READ) begin
                  addr_in = addr_ff + snf_pkg::POS_W'(read_n);
                  rem_in  = rem_ff - read_n;
               end else if (cmd_ff.kind == snf_pkg::CMD_WRITE && phase_ff) begin
                  addr_in = addr_ff + snf_pkg::POS_W'(write_n);
                  rem_in  = rem_ff - write_n;
                  room_in = RW'(PAGE_BYTES);
               end
               if (rsp.last) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      phase_ff <= phase_in;
      addr_ff  <= addr_in;
      rem_ff   <= rem_in;
      room_ff  <= room_in;
   end

endmodule
`default_nettype wire

/* rtl/spi_nor_flash_command_sequencer_unit.sv */
// A seek, read, read-ID or unknown request goes from the front end through the command
// queue and the back end into the result queue; a write or erase first has the front end
// find the page or sector remainder. The front end takes no new request until it has
// issued the last one; the back end emits one beat per cycle while the result queue has
// room, up to 64 per request, and returns to its idle state between requests. Reset
// clears the position to 0, sets max_chunk to 512 and empties both queues.
`default_nettype none
`include "spi_nor_flash_command_sequencer_unit_macros.svh"
module spi_nor_flash_command_sequencer_unit #(
   parameter int FLASH_BYTES  = 8388608,
   parameter int PAGE_BYTES   = 256,
   parameter int SECTOR_BYTES = 4096,
   parameter int BUFFER_BYTES = 512,
   parameter int MAX_REQUEST  = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   output logic                            full,
   input  wire logic [2:0]                 req_func,
   input  wire logic [23:0]                req_target_addr,
   input  wire logic [10:0]                req_byte_count,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [9:0]                 csr_data,
   output logic                            empty,
   input  wire logic                       pop,
   output logic                            rsp_is_transaction,
   output logic [7:0]                      rsp_spi_opcode,
   output logic                            rsp_has_address,
   output logic [23:0]                     rsp_spi_address,
   output logic [9:0]                      rsp_data_count,
   output logic                            rsp_poll_after,
   output logic                            rsp_status,
   output logic [23:0]                     rsp_position,
   output logic                            rsp_last
);
   logic [snf_pkg::CNT_W-1:0] max_chunk_ff, max_chunk_in;
   logic                      cmd_push, cmd_full, cmd_pop, cmd_empty;
   snf_pkg::cmd_type          cmd_wr, cmd_rd;
   logic                      beat_push, beat_full;
   snf_pkg::rsp_type          beat_wr, beat_rd;

   assign csr_ready    = 1'b1;
   assign max_chunk_in = (csr_valid && csr_ready) ? csr_data : max_chunk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chunk_ff <= 10'd512;
      end else begin
         max_chunk_ff <= max_chunk_in;
      end
   end

   snf_front #(
      .FLASH_BYTES  (FLASH_BYTES),
      .PAGE_BYTES   (PAGE_BYTES),
      .SECTOR_BYTES (SECTOR_BYTES),
      .BUFFER_BYTES (BUFFER_BYTES),
      .MAX_REQUEST  (MAX_REQUEST)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .func        (req_func),
      .target_addr (req_target_addr),
      .byte_count  (req_byte_count),
      .max_chunk   (max_chunk_ff),
      .cmd_push    (cmd_push),
      .cmd_full    (cmd_full),
      .cmd         (cmd_wr)
   );

   snf_fifo #(
      .WIDTH ($bits(snf_pkg::cmd_type)),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .full  (cmd_full),
      .wdata (cmd_wr),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .rdata (cmd_rd)
   );

   snf_back #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd_rd),
      .rsp_push  (beat_push),
      .rsp_full  (beat_full),
      .rsp       (beat_wr)
   );

   snf_fifo #(
      .WIDTH ($bits(snf_pkg::rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (beat_push),
      .full  (beat_full),
      .wdata (beat_wr),
      .pop   (pop),
      .empty (empty),
      .rdata (beat_rd)
   );

   assign rsp_is_transaction = beat_rd.is_transaction;
   assign rsp_spi_opcode     = beat_rd.spi_opcode;
   assign rsp_has_address    = beat_rd.has_address;
   assign rsp_spi_address    = beat_rd.spi_address;
   assign rsp_data_count     = beat_rd.data_count;
   assign rsp_poll_after     = beat_rd.poll_after;
   assign rsp_status         = beat_rd.status;
   assign rsp_position       = beat_rd.position;
   assign rsp_last           = beat_rd.last;

   `SNF_ASSERT_NXT(a_busy_after_accept, clock, reset, push && !full, full,
      "front end took a request but did not go busy")
   `SNF_ASSERT_IMP(a_cmd_no_overflow, clock, reset, cmd_push, !cmd_full,
      "command pushed into a full queue")
   `SNF_ASSERT_IMP(a_beat_no_overflow, clock, reset, beat_push, !beat_full,
      "result beat pushed into a full queue")
   `SNF_ASSERT_IMP(a_error_is_status_only, clock, reset, !empty && rsp_status,
      !rsp_is_transaction && rsp_last, "rejected request produced a descriptor")

endmodule
`default_nettype wire
